// ===== hdl/mono_framebuffer_plotter_top_macros.svh =====
// assertion macros shared by the checker
`ifndef MONO_FRAMEBUFFER_PLOTTER_TOP_MACROS_SVH
`define MONO_FRAMEBUFFER_PLOTTER_TOP_MACROS_SVH

// same-cycle implication
`define MFB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mfb_pkg.sv =====
package mfb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int SCREEN_WIDTH_MAX  = 256;
  localparam int SCREEN_HEIGHT_MAX = 128;
  localparam int PAGE_ROWS         = 8;
  localparam int ADDR_MAX_W        =
    $clog2(SCREEN_WIDTH_MAX * ((SCREEN_HEIGHT_MAX + PAGE_ROWS - 1) / PAGE_ROWS));

  localparam logic [7:0] BITMAP_MSB = 8'h80;
  localparam logic [3:0] BITMAP_LEN = 4'd8;

  typedef enum logic [1:0] {
    CMD_PIXEL  = 2'd0,
    CMD_BITMAP = 2'd1,
    CMD_FILL   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_SET    = 2'd1,
    MODE_INVERT = 2'd2,
    MODE_KEEP   = 2'd3
  } mode_t;

  typedef struct packed {
    logic                  active;
    logic                  on_screen;
    logic [ADDR_MAX_W-1:0] addr;
    logic [7:0]            mask;
  } pix_info_t;

endpackage

// ===== hdl/mfb_store.sv =====
module mfb_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [mfb_pkg::ADDR_MAX_W-1:0] waddr,
  input  logic [7:0]                     wdata,
  input  logic                           re,
  input  logic [mfb_pkg::ADDR_MAX_W-1:0] raddr,
  output logic [7:0]                     rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(waddr)] <= wdata;
    end
    if (re) begin
      rdata <= mem[AW'(raddr)];
    end
  end

endmodule

// ===== hdl/mfb_pix.sv =====
module mfb_pix #(
  parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic [3:0]         slot,
  input  logic [3:0]         end_slot,
  input  logic [7:0]         bits,
  output mfb_pkg::pix_info_t info
);

  localparam int PAGES = (SCREEN_HEIGHT + mfb_pkg::PAGE_ROWS - 1) / mfb_pkg::PAGE_ROWS;
  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int AMW   = mfb_pkg::ADDR_MAX_W;

  logic signed [16:0] xi;
  logic [7:0]         shifted;

  // column of this slot, no wrap
  assign xi      = $signed({x[15], x}) + $signed({13'd0, slot});
  assign shifted = bits << slot[2:0];

  assign info.active    = (slot < end_slot) && shifted[7];
  assign info.on_screen = !xi[16] && (xi < $signed(17'(SCREEN_WIDTH))) &&
                          !y[15] && (y < $signed(16'(SCREEN_HEIGHT)));
  assign info.addr      = AMW'(xi[XW-1:0]) * AMW'(PAGES) + AMW'(y[15:3]);
  assign info.mask      = 8'd1 << y[2:0];

endmodule

// ===== hdl/mono_framebuffer_plotter_top.sv =====
// pixel plot and bitmap byte: ST_PLOT visits one column per slot for min(pixel_count,8) slots (1 for a pixel)
// (one read-modify-write per column, reads and writes overlapped on the store ports), then strobes
// read: through ST_RDOUT, strobe at the accepting edge itself if the index is outside the store
// fill: one store entry per cycle over all SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) entries; busy until strobe
// reset: the store is cleared one entry per cycle (1024 entries at default size), busy high
// results are never held off by the receiver and appear for exactly one cycle
module mono_framebuffer_plotter_top #(
  parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_x_coord,
  input  logic [15:0] in_y_coord,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_bitmap_bits,
  input  logic [3:0]  in_pixel_count,
  input  logic [7:0]  in_fill_value,
  input  logic [9:0]  in_byte_index,
  output logic        out_valid,
  output logic [7:0]  out_read_data,
  output logic        out_clipped
);

  localparam int PAGES = (SCREEN_HEIGHT + mfb_pkg::PAGE_ROWS - 1) / mfb_pkg::PAGE_ROWS;
  localparam int STORE_DEPTH = SCREEN_WIDTH * PAGES;
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int AMW = mfb_pkg::ADDR_MAX_W;
  localparam logic [AW-1:0] SWEEP_LAST = AW'(STORE_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_PLOT,
    ST_RDOUT
  } state_t;

  state_t              state_r, state_nxt;
  logic signed [15:0]  x_r, x_nxt;
  logic signed [15:0]  y_r, y_nxt;
  mfb_pkg::mode_t      mode_r, mode_nxt;
  logic [7:0]          bits_r, bits_nxt;
  logic [3:0]          end_r, end_nxt;
  logic [3:0]          slot_r, slot_nxt;
  logic                clip_r, clip_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [AMW-1:0]      pend_addr_r, pend_addr_nxt;
  logic [7:0]          pend_mask_r, pend_mask_nxt;
  logic [AW-1:0]       sweep_r, sweep_nxt;
  logic [7:0]          fill_r, fill_nxt;
  logic                sweep_rep_r, sweep_rep_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_read_data_r, out_read_data_nxt;
  logic                out_clipped_r, out_clipped_nxt;

  mfb_pkg::pix_info_t  cur;
  logic                issue;
  logic                mem_we, mem_re;
  logic [AMW-1:0]      mem_waddr, mem_raddr;
  logic [7:0]          mem_wdata, mem_rdata, modified;

  mfb_pix #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_pix (
    .x        (x_r),
    .y        (y_r),
    .slot     (slot_r),
    .end_slot (end_r),
    .bits     (bits_r),
    .info     (cur)
  );

  mfb_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    case (mode_r)
      mfb_pkg::MODE_CLEAR:  modified = mem_rdata & ~pend_mask_r;
      mfb_pkg::MODE_SET:    modified = mem_rdata | pend_mask_r;
      mfb_pkg::MODE_INVERT: modified = mem_rdata ^ pend_mask_r;
      default:              modified = mem_rdata;
    endcase
  end

  assign issue = cur.active && cur.on_screen && (mode_r != mfb_pkg::MODE_KEEP);

  always_comb begin
    state_nxt         = state_r;
    x_nxt             = x_r;
    y_nxt             = y_r;
    mode_nxt          = mode_r;
    bits_nxt          = bits_r;
    end_nxt           = end_r;
    slot_nxt          = slot_r;
    clip_nxt          = clip_r;
    pend_vld_nxt      = 1'b0;
    pend_addr_nxt     = pend_addr_r;
    pend_mask_nxt     = pend_mask_r;
    sweep_nxt         = sweep_r;
    fill_nxt          = fill_r;
    sweep_rep_nxt     = sweep_rep_r;
    out_valid_nxt     = 1'b0;
    out_read_data_nxt = 8'd0;
    out_clipped_nxt   = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = pend_addr_r;
    mem_wdata         = modified;
    mem_re            = 1'b0;
    mem_raddr         = cur.addr;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          x_nxt    = $signed(in_x_coord);
          y_nxt    = $signed(in_y_coord);
          mode_nxt = mfb_pkg::mode_t'(in_mode);
          slot_nxt = 4'd0;
          clip_nxt = 1'b0;
          case (mfb_pkg::cmd_t'(in_command))
            mfb_pkg::CMD_PIXEL: begin
              bits_nxt  = mfb_pkg::BITMAP_MSB;
              end_nxt   = 4'd1;
              state_nxt = ST_PLOT;
            end
            mfb_pkg::CMD_BITMAP: begin
              bits_nxt  = in_bitmap_bits;
              end_nxt   = (in_pixel_count > mfb_pkg::BITMAP_LEN) ? mfb_pkg::BITMAP_LEN
                                                                   : in_pixel_count;
              state_nxt = ST_PLOT;
            end
            mfb_pkg::CMD_FILL: begin
              fill_nxt      = in_fill_value;
              sweep_nxt     = '0;
              sweep_rep_nxt = 1'b1;
              state_nxt     = ST_SWEEP;
            end
            default: begin
              if (32'(in_byte_index) < STORE_DEPTH) begin
                mem_re    = 1'b1;
                mem_raddr = AMW'(in_byte_index);
                state_nxt = ST_RDOUT;
              end else begin
                out_valid_nxt   = 1'b1;
                out_clipped_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = AMW'(sweep_r);
        mem_wdata = fill_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == SWEEP_LAST) begin
          out_valid_nxt = sweep_rep_r;
          sweep_rep_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_PLOT: begin
        // write back the column read last cycle, read the next one
        mem_we = pend_vld_r;
        if (slot_r == end_r) begin
          out_valid_nxt   = 1'b1;
          out_clipped_nxt = clip_r;
          state_nxt       = ST_IDLE;
        end else begin
          mem_re        = issue;
          pend_vld_nxt  = issue;
          pend_addr_nxt = cur.addr;
          pend_mask_nxt = cur.mask;
          clip_nxt      = clip_r | (cur.active & ~cur.on_screen);
          slot_nxt      = slot_r + 4'd1;
        end
      end
      ST_RDOUT: begin
        out_valid_nxt     = 1'b1;
        out_read_data_nxt = mem_rdata;
        state_nxt         = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_SWEEP;
      sweep_r         <= '0;
      fill_r          <= 8'd0;
      sweep_rep_r     <= 1'b0;
      pend_vld_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      out_read_data_r <= 8'd0;
      out_clipped_r   <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      sweep_r         <= sweep_nxt;
      fill_r          <= fill_nxt;
      sweep_rep_r     <= sweep_rep_nxt;
      pend_vld_r      <= pend_vld_nxt;
      out_valid_r     <= out_valid_nxt;
      out_read_data_r <= out_read_data_nxt;
      out_clipped_r   <= out_clipped_nxt;
    end
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    mode_r      <= mode_nxt;
    bits_r      <= bits_nxt;
    end_r       <= end_nxt;
    slot_r      <= slot_nxt;
    clip_r      <= clip_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_mask_r <= pend_mask_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_clipped   = out_clipped_r;

endmodule

// ===== hdl/mfb_check.sv =====
`include "mono_framebuffer_plotter_top_macros.svh"

module mfb_check (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic [7:0] out_read_data,
  input logic       out_clipped
);

  logic [1:0] last_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cmd_r <= mfb_pkg::CMD_PIXEL;
    end else if (start && !busy) begin
      last_cmd_r <= in_command;
    end
  end

  `MFB_ASSERT_SAME(a_idle_on_result, out_valid, !busy, "result shown while busy")
  `MFB_ASSERT_NEXT(a_busy_after_fill, start && !busy && in_command == mfb_pkg::CMD_FILL, busy, "fill did not hold busy")
  `MFB_ASSERT_SAME(a_quiet_outputs, !out_valid, out_read_data == 8'd0 && !out_clipped, "result ports not quiet")
  `MFB_ASSERT_SAME(a_data_only_on_read, out_valid && last_cmd_r != mfb_pkg::CMD_READ, out_read_data == 8'd0, "data on non-read result")

endmodule

bind mono_framebuffer_plotter_top mfb_check u_mfb_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_command    (in_command),
  .out_valid     (out_valid),
  .out_read_data (out_read_data),
  .out_clipped   (out_clipped)
);
